### sv/assert_macros.svh
// Assertion macros shared by the ring buffer FIFO modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/rbf_pkg.sv
// Types and constants shared by the ring buffer FIFO modules
`timescale 1ns / 1ps

package rbf_pkg;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_GET   = 2'd1;
    localparam logic [1:0] FUNC_PEEK  = 2'd2;
    localparam logic [1:0] FUNC_FLUSH = 2'd3;

    localparam int        CFG_ADDR_W    = 3;
    localparam logic      REG_RING_SIZE = 1'b0;
    localparam logic [4:0] RING_SIZE_RST = 5'd16;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 4;
    localparam int OFFSET_W  = 4;
    localparam int SIZE_REG_W = 5;

    // Outcome of one request, as decided in the issue cycle
    typedef struct packed {
        logic               ok;
        logic               rd;
        logic [COUNT_W-1:0] count;
        logic               full;
        logic               empty;
    } t_res;

endpackage

### sv/rbf_mem.sv
// Slot store: single-port synchronous RAM with registered read
`timescale 1ns / 1ps

module rbf_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rbf_ctrl.sv
// Pointer control: fill count, request decision and RAM access
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbf_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic [1:0]                        i_func,
    input  logic [rbf_pkg::OFFSET_W-1:0]      i_offset,
    input  logic [rbf_pkg::SIZE_REG_W-1:0]    i_ring_size,
    input  logic                              i_cfg_clr,
    output logic                              o_we,
    output logic                              o_re,
    output logic [$clog2(DEPTH)-1:0]          o_addr,
    output rbf_pkg::t_res                     o_res
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int DW    = $clog2(DEPTH + 1);
    localparam int SZ_W  = (DW > rbf_pkg::SIZE_REG_W) ? DW : rbf_pkg::SIZE_REG_W;

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;

    logic [SZ_W-1:0] size_x;
    logic [SZ_W-1:0] n_slots;
    logic [SZ_W-1:0] wp_x;
    logic [SZ_W-1:0] rp_x;
    logic [SZ_W-1:0] cnt;
    logic [SZ_W-1:0] cnt_after;
    logic [SZ_W:0]   peek_sum;
    logic [SZ_W:0]   peek_idx;
    logic            can_put;
    logic            can_get;
    logic            can_peek;
    logic            ok;
    logic            rd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [SZ_W-1:0] n);
        logic [SZ_W-1:0] nxt;
        nxt = SZ_W'(p) + SZ_W'(1);
        return (nxt == n) ? PTR_W'(0) : PTR_W'(nxt);
    endfunction

    // clamp the size register to 2..DEPTH
    always_comb begin
        size_x = SZ_W'(i_ring_size);
        if (size_x < SZ_W'(2)) begin
            n_slots = SZ_W'(2);
        end else if (size_x > SZ_W'(DEPTH)) begin
            n_slots = SZ_W'(DEPTH);
        end else begin
            n_slots = size_x;
        end
    end

    assign wp_x = SZ_W'(r_wp);
    assign rp_x = SZ_W'(r_rp);
    assign cnt  = (wp_x >= rp_x) ? (wp_x - rp_x) : (wp_x + n_slots - rp_x);

    assign can_put  = (cnt < (n_slots - SZ_W'(1)));
    assign can_get  = (cnt != '0);
    assign can_peek = (SZ_W'(i_offset) < cnt);

    assign peek_sum = (SZ_W + 1)'(rp_x) + (SZ_W + 1)'(i_offset);
    assign peek_idx = (peek_sum >= (SZ_W + 1)'(n_slots))
                    ? (peek_sum - (SZ_W + 1)'(n_slots)) : peek_sum;

    always_comb begin
        ok        = 1'b0;
        rd        = 1'b0;
        n_wp      = r_wp;
        n_rp      = r_rp;
        cnt_after = cnt;
        o_addr    = r_rp;
        unique case (i_func)
            rbf_pkg::FUNC_PUT: begin
                ok     = can_put;
                o_addr = r_wp;
                if (can_put) begin
                    n_wp      = ptr_inc(r_wp, n_slots);
                    cnt_after = cnt + SZ_W'(1);
                end
            end
            rbf_pkg::FUNC_GET: begin
                ok = can_get;
                rd = can_get;
                if (can_get) begin
                    n_rp      = ptr_inc(r_rp, n_slots);
                    cnt_after = cnt - SZ_W'(1);
                end
            end
            rbf_pkg::FUNC_PEEK: begin
                ok     = can_peek;
                rd     = can_peek;
                o_addr = PTR_W'(peek_idx);
            end
            rbf_pkg::FUNC_FLUSH: begin
                ok        = 1'b1;
                n_wp      = '0;
                n_rp      = '0;
                cnt_after = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign o_we = i_acc && (i_func == rbf_pkg::FUNC_PUT) && ok;
    assign o_re = i_acc && rd;

    assign o_res.ok    = ok;
    assign o_res.rd    = rd;
    assign o_res.count = cnt_after[rbf_pkg::COUNT_W-1:0];
    assign o_res.full  = (cnt_after == (n_slots - SZ_W'(1)));
    assign o_res.empty = (cnt_after == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_clr) begin
            r_wp <= '0;
            r_rp <= '0;
        end else if (i_acc) begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    `ASSERT_ALWAYS(a_wp_range, i_clk, i_rst_n, SZ_W'(r_wp) < n_slots, "write pointer past ring")
    `ASSERT_ALWAYS(a_rp_range, i_clk, i_rst_n, SZ_W'(r_rp) < n_slots, "read pointer past ring")
    `ASSERT_NEXT(a_peek_hold, i_clk, i_rst_n, i_acc && !i_cfg_clr && (i_func == rbf_pkg::FUNC_PEEK), (r_wp == $past(r_wp)) && (r_rp == $past(r_rp)), "peek moved a pointer")

endmodule

### sv/ring_buffer_fifo_with_peek_core.sv
// Ring buffer FIFO with peek: stream ports, size register and result pipeline
// Path: an accepted request passes the issue stage and then the output register to m_tvalid.
// Throughput: one request per cycle while m_tready is high; the issue stage with its registered
// RAM read and the output register form a two-deep pipeline that stalls only while m_tready is low.
// Reset: both pointers go to zero and ring_size to 16; the slot RAM is not cleared,
// and no slot can be read before a put has written it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ring_buffer_fifo_with_peek_core #(
    parameter int DEPTH     = 16,
    parameter int ITEM_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request: [1:0] func, [33:2] data_in, [37:34] offset, [39:38] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rbf_pkg::S_TDATA_W-1:0]     s_tdata,
    // result: [0] ok, [32:1] data_out, [36:33] count, [37] full_res,
    // [38] empty_res, [39] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rbf_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rbf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = (ITEM_BITS < rbf_pkg::DATA_W) ? ITEM_BITS : rbf_pkg::DATA_W;

    logic [rbf_pkg::SIZE_REG_W-1:0] r_ring_size;
    logic                           cfg_wr;

    logic [1:0]                     req_func;
    logic [rbf_pkg::DATA_W-1:0]     req_data;
    logic [rbf_pkg::OFFSET_W-1:0]   req_offset;

    logic             acc;
    logic             s1_move;
    logic             r_s1_v;
    rbf_pkg::t_res    r_s1_res;
    rbf_pkg::t_res    res;
    logic             mem_we;
    logic             mem_re;
    logic [PTR_W-1:0] mem_addr;
    logic [ITEM_BITS-1:0] mem_rdata;
    logic [rbf_pkg::DATA_W-1:0] s1_data;

    logic                         r_out_v;
    logic                         r_out_ok;
    logic [rbf_pkg::DATA_W-1:0]   r_out_data;
    logic [rbf_pkg::COUNT_W-1:0]  r_out_count;
    logic                         r_out_full;
    logic                         r_out_empty;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rbf_pkg::REG_RING_SIZE);
    assign prdata = (paddr[2] == rbf_pkg::REG_RING_SIZE) ? 32'(r_ring_size) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= rbf_pkg::RING_SIZE_RST;
        end else if (cfg_wr) begin
            r_ring_size <= pwdata[rbf_pkg::SIZE_REG_W-1:0];
        end
    end

    assign req_func   = s_tdata[1:0];
    assign req_data   = s_tdata[33:2];
    assign req_offset = s_tdata[37:34];

    // advance the issue stage whenever the output register is free or drains
    assign s1_move  = r_s1_v && (!r_out_v || m_tready);
    assign s_tready = !r_s1_v || s1_move;
    assign acc      = s_tvalid && s_tready;

    rbf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_func     (req_func),
        .i_offset   (req_offset),
        .i_ring_size(r_ring_size),
        .i_cfg_clr  (cfg_wr),
        .o_we       (mem_we),
        .o_re       (mem_re),
        .o_addr     (mem_addr),
        .o_res      (res)
    );

    rbf_mem #(
        .DEPTH(DEPTH),
        .WIDTH(ITEM_BITS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_re   (mem_re),
        .i_addr (mem_addr),
        .i_wdata(ITEM_BITS'(req_data[CW-1:0])),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_move) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_res <= res;
        end
    end

    // drop read data for puts, flushes and failed requests
    assign s1_data = r_s1_res.rd ? rbf_pkg::DATA_W'(mem_rdata[CW-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_move) begin
            r_out_v <= 1'b1;
        end else if (m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_ok    <= r_s1_res.ok;
            r_out_data  <= s1_data;
            r_out_count <= r_s1_res.count;
            r_out_full  <= r_s1_res.full;
            r_out_empty <= r_s1_res.empty;
        end
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = {1'b0, r_out_empty, r_out_full, r_out_count, r_out_data, r_out_ok};

    `ASSERT_NEXT(a_issue_fill, i_clk, i_rst_n, acc, r_s1_v, "accepted request lost in issue stage")
    `ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, s1_move, r_out_v, "issued request lost before output")
    `ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, r_out_v && !r_out_ok, r_out_data == '0, "failed request carries data")
    `ASSERT_IMPLY(a_empty_cnt, i_clk, i_rst_n, r_out_v && r_out_empty, r_out_count == '0, "empty flag with nonzero count")

endmodule

### dv/testbench.sv
// Self-checking testbench for the ring buffer FIFO with peek: stream requests, size register
`timescale 1ns / 1ps

module testbench;

    localparam int MEM_DEPTH   = 16;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_OPS   = 88;
    localparam int DRAIN_WAIT  = 6;

    typedef struct packed {
        logic [1:0]                   func;
        logic [rbf_pkg::DATA_W-1:0]   data;
        logic [rbf_pkg::OFFSET_W-1:0] offset;
    } t_fifo_req;

    typedef struct packed {
        logic                         ok;
        logic [rbf_pkg::DATA_W-1:0]   data;
        logic [rbf_pkg::COUNT_W-1:0]  count;
        logic                         full;
        logic                         empty;
    } t_fifo_resp;

    logic                               i_clk    = 1'b0;
    logic                               i_rst_n  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [rbf_pkg::S_TDATA_W-1:0]      s_tdata  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [rbf_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [rbf_pkg::CFG_ADDR_W-1:0]     paddr    = '0;
    logic [31:0]                        pwdata   = '0;
    logic [31:0]                        prdata;
    logic                               pready;

    // predicted block state
    logic [rbf_pkg::DATA_W-1:0]         slot_mem [MEM_DEPTH];
    int                                 wr_ptr   = 0;
    int                                 rd_ptr   = 0;
    logic [rbf_pkg::SIZE_REG_W-1:0]     size_reg = rbf_pkg::RING_SIZE_RST;

    t_fifo_req              op_queue[$];
    t_fifo_resp             pending_resp_q[$];
    t_fifo_req              in_flight;
    int                     issued_cnt   = 0;
    int                     accepted_cnt = 0;
    int                     mismatch_cnt = 0;
    int                     send_idle_pct = 27;
    int                     recv_idle_pct = 60;

    // generator-side fill tracking, used only to shape offsets and op mix
    int                     gen_count = 0;
    int                     gen_n     = MEM_DEPTH;
    bit                     fill_bias = 1'b1;

    ring_buffer_fifo_with_peek_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int clamp_size(logic [rbf_pkg::SIZE_REG_W-1:0] sz);
        if (sz < 2)
            return 2;
        if (sz > MEM_DEPTH)
            return MEM_DEPTH;
        return int'(sz);
    endfunction

    function automatic t_fifo_resp compute_fifo_response(t_fifo_req r);
        int         n;
        int         cnt;
        t_fifo_resp o;
        n   = clamp_size(size_reg);
        cnt = (n - rd_ptr + wr_ptr) % n;
        o   = '0;
        case (r.func)
            rbf_pkg::FUNC_PUT: begin
                if (cnt < n - 1) begin
                    slot_mem[wr_ptr] = r.data;
                    wr_ptr = (wr_ptr + 1) % n;
                    o.ok = 1'b1;
                end
            end
            rbf_pkg::FUNC_GET: begin
                if (cnt != 0) begin
                    o.data = slot_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % n;
                    o.ok = 1'b1;
                end
            end
            rbf_pkg::FUNC_PEEK: begin
                if (cnt != 0 && int'(r.offset) < cnt) begin
                    o.data = slot_mem[(rd_ptr + int'(r.offset)) % n];
                    o.ok = 1'b1;
                end
            end
            default: begin
                wr_ptr = 0;
                rd_ptr = 0;
                o.ok = 1'b1;
            end
        endcase
        cnt     = (n - rd_ptr + wr_ptr) % n;
        o.count = cnt[rbf_pkg::COUNT_W-1:0];
        o.full  = (cnt == n - 1);
        o.empty = (cnt == 0);
        return o;
    endfunction

    // Driver: hold a request until accepted, predict its result on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready
                    && paddr[rbf_pkg::CFG_ADDR_W-1:2] == rbf_pkg::REG_RING_SIZE) begin
                size_reg = pwdata[rbf_pkg::SIZE_REG_W-1:0];
                wr_ptr = 0;
                rd_ptr = 0;
            end
            if (s_tvalid && s_tready) begin
                pending_resp_q.push_back(compute_fifo_response(in_flight));
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_flight = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, in_flight.offset, in_flight.data, in_flight.func};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_fifo_resp act;
        t_fifo_resp exp_r;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                act.ok    = m_tdata[0];
                act.data  = m_tdata[32:1];
                act.count = m_tdata[36:33];
                act.full  = m_tdata[37];
                act.empty = m_tdata[38];
                if (pending_resp_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result ok=%0b data=%h count=%0d full=%0b empty=%0b",
                             $time, act.ok, act.data, act.count, act.full, act.empty);
                end else begin
                    exp_r = pending_resp_q.pop_front();
                    if (act.ok !== exp_r.ok || act.data !== exp_r.data
                            || act.count !== exp_r.count || act.full !== exp_r.full
                            || act.empty !== exp_r.empty) begin
                        mismatch_cnt++;
                        $display("%0t: mismatch exp ok=%0b data=%h count=%0d full=%0b empty=%0b",
                                 $time, exp_r.ok, exp_r.data, exp_r.count, exp_r.full,
                                 exp_r.empty);
                        $display("%0t:          act ok=%0b data=%h count=%0d full=%0b empty=%0b",
                                 $time, act.ok, act.data, act.count, act.full, act.empty);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic queue_op(logic [1:0] func, logic [rbf_pkg::DATA_W-1:0] data,
                            logic [rbf_pkg::OFFSET_W-1:0] offset);
        t_fifo_req r;
        r.func   = func;
        r.data   = data;
        r.offset = offset;
        op_queue.push_back(r);
        issued_cnt++;
        case (func)
            rbf_pkg::FUNC_PUT:   if (gen_count < gen_n - 1) gen_count++;
            rbf_pkg::FUNC_GET:   if (gen_count > 0) gen_count--;
            rbf_pkg::FUNC_FLUSH: gen_count = 0;
            default: ;
        endcase
    endtask

    task automatic queue_random_op();
        int                           roll;
        logic [1:0]                   f;
        logic [rbf_pkg::DATA_W-1:0]   d;
        logic [rbf_pkg::OFFSET_W-1:0] off;
        // swing between filling and draining so full and empty both get hit
        if ($urandom_range(0, 11) == 0
                || (fill_bias && gen_count == gen_n - 1 && $urandom_range(0, 2) == 0)
                || (!fill_bias && gen_count == 0 && $urandom_range(0, 2) == 0))
            fill_bias = !fill_bias;
        roll = $urandom_range(0, 99);
        if (roll < (fill_bias ? 55 : 20))
            f = rbf_pkg::FUNC_PUT;
        else if (roll < (fill_bias ? 75 : 65))
            f = rbf_pkg::FUNC_GET;
        else if (roll < 97)
            f = rbf_pkg::FUNC_PEEK;
        else
            f = rbf_pkg::FUNC_FLUSH;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = '1;
            default: d = $urandom;
        endcase
        if ($urandom_range(0, 99) < 85)
            off = rbf_pkg::OFFSET_W'($urandom_range(0, gen_count));
        else
            off = rbf_pkg::OFFSET_W'($urandom_range(0, 15));
        queue_op(f, d, off);
    endtask

    task automatic wait_drained();
        while (accepted_cnt != issued_cnt || pending_resp_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_ring_size(logic [rbf_pkg::SIZE_REG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rbf_pkg::CFG_ADDR_W'(rbf_pkg::REG_RING_SIZE) << 2;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // read back at the end of the access cycle
        if (prdata !== 32'(value)) begin
            mismatch_cnt++;
            $display("%0t: ring_size readback exp=%h act=%h", $time, 32'(value), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        gen_n     = clamp_size(value);
        gen_count = 0;
    endtask

    initial begin
        logic [rbf_pkg::SIZE_REG_W-1:0] sizes [RAND_PHASES];

        sizes = '{5'd16, 5'd2, 5'd3, 5'd0, 5'd1, 5'd31, 5'd17, 5'd5, 5'd9, 5'd15, 5'd4, 5'd16};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty errors, data extremes, peek bounds, flush, two-slot ring
        queue_op(rbf_pkg::FUNC_GET,   32'h0, 4'd0);
        queue_op(rbf_pkg::FUNC_PEEK,  32'h0, 4'd0);
        queue_op(rbf_pkg::FUNC_PUT,   32'h0000_0000, 4'd15);
        queue_op(rbf_pkg::FUNC_PUT,   32'hFFFF_FFFF, 4'd0);
        queue_op(rbf_pkg::FUNC_PUT,   32'hA5A5_5A5A, 4'd0);
        queue_op(rbf_pkg::FUNC_PEEK,  32'h0, 4'd2);
        queue_op(rbf_pkg::FUNC_PEEK,  32'h0, 4'd3);
        queue_op(rbf_pkg::FUNC_PEEK,  32'h0, 4'd15);
        queue_op(rbf_pkg::FUNC_GET,   32'h0, 4'd0);
        queue_op(rbf_pkg::FUNC_PEEK,  32'h0, 4'd1);
        queue_op(rbf_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 4'd15);
        queue_op(rbf_pkg::FUNC_GET,   32'h0, 4'd0);
        queue_op(rbf_pkg::FUNC_FLUSH, 32'h0, 4'd0);
        wait_drained();

        write_ring_size(5'd2);
        queue_op(rbf_pkg::FUNC_PUT,   32'h1234_5678, 4'd0);
        queue_op(rbf_pkg::FUNC_PUT,   32'h8765_4321, 4'd0);
        queue_op(rbf_pkg::FUNC_PEEK,  32'h0, 4'd0);
        queue_op(rbf_pkg::FUNC_PEEK,  32'h0, 4'd1);
        queue_op(rbf_pkg::FUNC_GET,   32'h0, 4'd0);
        queue_op(rbf_pkg::FUNC_PUT,   32'hDEAD_BEEF, 4'd0);
        queue_op(rbf_pkg::FUNC_GET,   32'h0, 4'd0);
        queue_op(rbf_pkg::FUNC_GET,   32'h0, 4'd0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph / 4)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_ring_size(sizes[ph]);
            fill_bias = 1'b1;
            for (int k = 0; k < PHASE_OPS; k++)
                queue_random_op();
            wait_drained();
        end

        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
